@@ src/assert_macros.svh @@
// assertion macros used by the rtl register block
// each check is sampled on the rising clock edge and is off while reset is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ src/acia_sr_pkg.sv @@
package acia_sr_pkg;

    // transaction kinds on the input stream
    typedef enum logic [2:0] {
        OP_CTRL_WRITE  = 3'd0,
        OP_TX_WRITE    = 3'd1,
        OP_STATUS_READ = 3'd2,
        OP_RX_READ     = 3'd3,
        OP_BYTE_RX     = 3'd4,
        OP_TX_READY    = 3'd5
    } op_t;

    // status bit positions
    localparam int ST_RDRF = 0;
    localparam int ST_TDRE = 1;
    localparam int ST_OVRN = 5;

    // status after reset and after master reset
    localparam logic [6:0] STATUS_RESET = 7'h02;
    // bits latched by a status read (carrier detect and overrun)
    localparam logic [7:0] FLAG_MASK = 8'h24;
    // overrun flag as a deferred flag
    localparam logic [7:0] FLAG_OVRN = 8'h20;

    // control field values
    localparam logic [1:0] DIV_MASTER_RESET = 2'b11;
    localparam logic [1:0] TXC_INT_ENABLE   = 2'b01;

    // one result item, read_data in the lowest bits
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       irq_line;
        logic [7:0] read_data;
    } result_t;

endpackage

@@ src/acia_serial_registers_top.sv @@
// a result appears on the output register in the cycle after its input transaction is taken
// throughput: one input transaction per cycle while the result stream does not stall
// an input transaction is taken while the output register is empty or being drained
// reset (rst_n low, asynchronous) sets control to zero, status to tdre only and
// clears the holding registers, flags, pending bits, enable and the output valid bit
module acia_serial_registers_top
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,       // enabled
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // data[7:0]
    input  logic [2:0]  s_tuser,        // op[2:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata         // read_data[7:0], irq_line[8], tx_valid[9],
                                        // tx_byte[17:10], zero[23:18]
);

    logic                  enabled_reg;
    logic [7:0]            control_reg, control_next;
    logic [6:0]            status_reg, status_next;
    logic [7:0]            flags_clr_reg, flags_clr_next;
    logic [7:0]            flags_def_reg, flags_def_next;
    logic [7:0]            tx_hold_reg, tx_hold_next;
    logic [7:0]            rx_hold_reg, rx_hold_next;
    logic                  rx_pend_reg, rx_pend_next;
    logic                  tx_pend_reg, tx_pend_next;
    logic                  out_valid_reg;
    acia_sr_pkg::result_t  res_reg, res_next;
    acia_sr_pkg::op_t      op;
    logic [7:0]            delta;
    logic                  in_accept;

    // handshakes
    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign op        = acia_sr_pkg::op_t'(s_tuser);
    assign delta     = control_reg ^ s_tdata;

    // register update for one transaction
    always_comb
    begin
        control_next   = control_reg;
        status_next    = status_reg;
        flags_clr_next = flags_clr_reg;
        flags_def_next = flags_def_reg;
        tx_hold_next   = tx_hold_reg;
        rx_hold_next   = rx_hold_reg;
        rx_pend_next   = rx_pend_reg;
        tx_pend_next   = tx_pend_reg;
        res_next       = '0;
        case (op)
            acia_sr_pkg::OP_CTRL_WRITE:
            begin
                control_next = s_tdata;
                // master reset on entry to divide code three
                if ((|delta[1:0]) && s_tdata[1:0] == acia_sr_pkg::DIV_MASTER_RESET)
                begin
                    rx_pend_next   = 1'b0;
                    tx_pend_next   = 1'b0;
                    status_next    = acia_sr_pkg::STATUS_RESET;
                    flags_clr_next = '0;
                    flags_def_next = '0;
                end
                if (|delta[6:5])
                    tx_pend_next = (s_tdata[6:5] == acia_sr_pkg::TXC_INT_ENABLE)
                                   && status_next[acia_sr_pkg::ST_TDRE];
                if (delta[7])
                    rx_pend_next = s_tdata[7] && status_next[acia_sr_pkg::ST_RDRF];
            end
            acia_sr_pkg::OP_TX_WRITE:
            begin
                tx_hold_next = s_tdata;
                status_next[acia_sr_pkg::ST_TDRE] = 1'b0;
                if (control_reg[6:5] == acia_sr_pkg::TXC_INT_ENABLE)
                    tx_pend_next = 1'b0;
            end
            acia_sr_pkg::OP_STATUS_READ:
            begin
                flags_clr_next     = {1'b0, status_reg} & acia_sr_pkg::FLAG_MASK;
                res_next.read_data = {rx_pend_reg | tx_pend_reg, status_reg};
            end
            acia_sr_pkg::OP_RX_READ:
            begin
                status_next = status_reg & ~flags_clr_reg[6:0];
                status_next[acia_sr_pkg::ST_RDRF] = 1'b0;
                status_next = status_next | flags_def_reg[6:0];
                flags_clr_next = '0;
                flags_def_next = '0;
                if (control_reg[7])
                    rx_pend_next = status_next[acia_sr_pkg::ST_RDRF]
                                   || status_next[acia_sr_pkg::ST_OVRN];
                res_next.read_data = rx_hold_reg;
            end
            acia_sr_pkg::OP_BYTE_RX:
            begin
                if (enabled_reg)
                begin
                    rx_hold_next = s_tdata;
                    // byte while still full defers an overrun
                    if (status_reg[acia_sr_pkg::ST_RDRF])
                        flags_def_next = flags_def_reg | acia_sr_pkg::FLAG_OVRN;
                    status_next[acia_sr_pkg::ST_RDRF] = 1'b1;
                    if (control_reg[7])
                        rx_pend_next = 1'b1;
                end
            end
            acia_sr_pkg::OP_TX_READY:
            begin
                if (enabled_reg && !status_reg[acia_sr_pkg::ST_TDRE])
                begin
                    status_next[acia_sr_pkg::ST_TDRE] = 1'b1;
                    if (control_reg[6:5] == acia_sr_pkg::TXC_INT_ENABLE)
                        tx_pend_next = 1'b1;
                    res_next.tx_valid = 1'b1;
                    res_next.tx_byte  = tx_hold_reg;
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
        res_next.irq_line = rx_pend_next | tx_pend_next;
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enabled_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            enabled_reg <= cfg_data;
    end

    // device state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg   <= '0;
            status_reg    <= acia_sr_pkg::STATUS_RESET;
            flags_clr_reg <= '0;
            flags_def_reg <= '0;
            tx_hold_reg   <= '0;
            rx_hold_reg   <= '0;
            rx_pend_reg   <= 1'b0;
            tx_pend_reg   <= 1'b0;
        end
        else if (in_accept)
        begin
            control_reg   <= control_next;
            status_reg    <= status_next;
            flags_clr_reg <= flags_clr_next;
            flags_def_reg <= flags_def_next;
            tx_hold_reg   <= tx_hold_next;
            rx_hold_reg   <= rx_hold_next;
            rx_pend_reg   <= rx_pend_next;
            tx_pend_reg   <= tx_pend_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_tready)
            out_valid_reg <= s_tvalid;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, res_reg};

    `include "assert_macros.svh"

    // rx pending only while rx interrupt is enabled
    `ASSERT_SAME(a_rx_pend_en, rx_pend_reg, control_reg[7])
    // tx pending only while tx interrupt is enabled
    `ASSERT_SAME(a_tx_pend_en, tx_pend_reg, control_reg[6:5] == acia_sr_pkg::TXC_INT_ENABLE)
    // irq in the result matches the pending bits it left behind
    `ASSERT_NEXT(a_irq_match, in_accept, m_tdata[8] == (rx_pend_reg | tx_pend_reg))
    // a tx data write empties nothing: tdre clears
    `ASSERT_NEXT(a_tx_write_tdre, in_accept && op == acia_sr_pkg::OP_TX_WRITE,
                 !status_reg[acia_sr_pkg::ST_TDRE])
    // a sent byte leaves the transmit register empty
    `ASSERT_NEXT(a_tx_sent_tdre, in_accept && res_next.tx_valid,
                 status_reg[acia_sr_pkg::ST_TDRE] && m_tdata[9])

endmodule

@@ test/tb_top.sv @@
module tb_top;

    // op codes with no register action, outside the package enum
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;
    // control register: receive interrupt enable bit
    localparam int CTL_RX_INT = 7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;
    localparam int IDLE_PERCENT = 27;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // shadow copy of the adapter registers
    logic [7:0]  ctl_reg = 8'h00;
    logic [6:0]  sts_reg = acia_sr_pkg::STATUS_RESET;
    logic [7:0]  latched_flags = 8'h00;
    logic [7:0]  deferred_flags = 8'h00;
    logic [7:0]  tx_hold = 8'h00;
    logic [7:0]  rx_hold = 8'h00;
    logic        rx_irq = 1'b0;
    logic        tx_irq = 1'b0;
    logic        line_enabled = 1'b0;

    // predicted replies still owed by the adapter, oldest first
    acia_sr_pkg::result_t acia_replies_q[$];

    bit          idle_on = 1'b1;
    int          rx_stall_left = 0;
    int          items_sent = 0;
    int          replies_checked = 0;
    int          mismatches = 0;
    int          line_bytes = 0;
    int          irq_replies = 0;
    int          enable_writes = 0;

    acia_serial_registers_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // register update for one transaction, returns the reply it causes
    function automatic acia_sr_pkg::result_t acia_update(input logic [2:0] op,
                                                         input logic [7:0] data);
        acia_sr_pkg::result_t r;
        logic [7:0] delta;
        logic       tx_int_on;
        r = '0;
        tx_int_on = (ctl_reg[6:5] == acia_sr_pkg::TXC_INT_ENABLE);
        case (op)
            acia_sr_pkg::OP_CTRL_WRITE:
            begin
                delta = ctl_reg ^ data;
                ctl_reg = data;
                tx_int_on = (ctl_reg[6:5] == acia_sr_pkg::TXC_INT_ENABLE);
                // master reset only on a change of the divide field to 3
                if (delta[1:0] != 2'b00 && ctl_reg[1:0] == acia_sr_pkg::DIV_MASTER_RESET)
                begin
                    rx_irq = 1'b0;
                    tx_irq = 1'b0;
                    sts_reg = acia_sr_pkg::STATUS_RESET;
                    latched_flags = '0;
                    deferred_flags = '0;
                end
                if (delta[6:5] != 2'b00)
                    tx_irq = tx_int_on && sts_reg[acia_sr_pkg::ST_TDRE];
                if (delta[CTL_RX_INT])
                    rx_irq = ctl_reg[CTL_RX_INT] && sts_reg[acia_sr_pkg::ST_RDRF];
            end
            acia_sr_pkg::OP_TX_WRITE:
            begin
                tx_hold = data;
                sts_reg[acia_sr_pkg::ST_TDRE] = 1'b0;
                if (tx_int_on)
                    tx_irq = 1'b0;
            end
            acia_sr_pkg::OP_STATUS_READ:
            begin
                latched_flags = {1'b0, sts_reg} & acia_sr_pkg::FLAG_MASK;
                r.read_data = {rx_irq | tx_irq, sts_reg};
            end
            acia_sr_pkg::OP_RX_READ:
            begin
                sts_reg[acia_sr_pkg::ST_RDRF] = 1'b0;
                sts_reg = (sts_reg & ~latched_flags[6:0]) | deferred_flags[6:0];
                latched_flags = '0;
                deferred_flags = '0;
                if (ctl_reg[CTL_RX_INT])
                    rx_irq = sts_reg[acia_sr_pkg::ST_RDRF] | sts_reg[acia_sr_pkg::ST_OVRN];
                r.read_data = rx_hold;
            end
            acia_sr_pkg::OP_BYTE_RX:
            begin
                if (line_enabled)
                begin
                    rx_hold = data;
                    // byte while full: overrun is held back until the next rx read
                    if (sts_reg[acia_sr_pkg::ST_RDRF])
                        deferred_flags = deferred_flags | acia_sr_pkg::FLAG_OVRN;
                    sts_reg[acia_sr_pkg::ST_RDRF] = 1'b1;
                    if (ctl_reg[CTL_RX_INT])
                        rx_irq = 1'b1;
                end
            end
            acia_sr_pkg::OP_TX_READY:
            begin
                if (line_enabled && !sts_reg[acia_sr_pkg::ST_TDRE])
                begin
                    sts_reg[acia_sr_pkg::ST_TDRE] = 1'b1;
                    if (tx_int_on)
                        tx_irq = 1'b1;
                    r.tx_valid = 1'b1;
                    r.tx_byte = tx_hold;
                end
            end
            default:
            begin
            end
        endcase
        r.irq_line = rx_irq | tx_irq;
        return r;
    endfunction

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(input logic [2:0] op, input logic [7:0] data);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        acia_replies_q.push_back(acia_update(op, data));
        items_sent++;
    endtask

    // stop offering and wait for every owed reply
    task automatic wait_replies();
        s_tvalid <= 1'b0;
        while (acia_replies_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // enable register write, only with the adapter idle
    task automatic write_enable(input logic value);
        wait_replies();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        line_enabled = value;
        enable_writes++;
    endtask

    // control byte, mostly without a master reset
    function automatic logic [7:0] rand_ctrl();
        logic [7:0] v;
        v = 8'($urandom_range(255));
        if ($urandom_range(99) >= 15)
            v[1:0] = 2'($urandom_range(2));
        return v;
    endfunction

    // a short register sequence of the kind a driver would issue, or noise
    task automatic send_rand_seq();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            send_item(acia_sr_pkg::OP_BYTE_RX, 8'($urandom_range(255)));
            if ($urandom_range(99) < 30)
                send_item(acia_sr_pkg::OP_BYTE_RX, 8'($urandom_range(255)));
            send_item(acia_sr_pkg::OP_STATUS_READ, 8'($urandom_range(255)));
            send_item(acia_sr_pkg::OP_RX_READ, 8'($urandom_range(255)));
        end
        else if (pick < 45)
        begin
            send_item(acia_sr_pkg::OP_TX_WRITE, 8'($urandom_range(255)));
            if ($urandom_range(1) == 1)
                send_item(acia_sr_pkg::OP_STATUS_READ, 8'($urandom_range(255)));
            send_item(acia_sr_pkg::OP_TX_READY, 8'($urandom_range(255)));
        end
        else if (pick < 55)
            send_item(acia_sr_pkg::OP_CTRL_WRITE, rand_ctrl());
        else if (pick < 65)
        begin
            send_item(acia_sr_pkg::OP_STATUS_READ, 8'($urandom_range(255)));
            send_item(acia_sr_pkg::OP_RX_READ, 8'($urandom_range(255)));
        end
        else if (pick < 88)
            send_item(3'($urandom_range(5)), 8'($urandom_range(255)));
        else
            send_item(3'($urandom_range(7)), 8'($urandom_range(255)));
    endtask

    task automatic run_seqs(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
            send_rand_seq();
    endtask

    // register extremes and each special case
    task automatic test_directed_cases();
        write_enable(1'b0);
        // line events are dropped while disabled
        send_item(acia_sr_pkg::OP_BYTE_RX, 8'hFF);
        send_item(acia_sr_pkg::OP_TX_WRITE, 8'hA5);
        send_item(acia_sr_pkg::OP_TX_READY, 8'h00);
        send_item(acia_sr_pkg::OP_STATUS_READ, 8'h00);
        write_enable(1'b1);
        send_item(acia_sr_pkg::OP_CTRL_WRITE, 8'hFF);
        send_item(acia_sr_pkg::OP_CTRL_WRITE, 8'hA0);
        send_item(acia_sr_pkg::OP_TX_WRITE, 8'hFF);
        send_item(acia_sr_pkg::OP_TX_READY, 8'h5A);
        // nothing left to send
        send_item(acia_sr_pkg::OP_TX_READY, 8'h00);
        send_item(acia_sr_pkg::OP_BYTE_RX, 8'h00);
        // overrun on a full receiver
        send_item(acia_sr_pkg::OP_BYTE_RX, 8'hFF);
        send_item(acia_sr_pkg::OP_STATUS_READ, 8'h00);
        send_item(acia_sr_pkg::OP_RX_READ, 8'h00);
        send_item(acia_sr_pkg::OP_STATUS_READ, 8'h00);
        send_item(acia_sr_pkg::OP_RX_READ, 8'hFF);
        send_item(OP_RSVD_6, 8'hFF);
        send_item(OP_RSVD_7, 8'hFF);
        // master reset, then the same value again with no reset
        send_item(acia_sr_pkg::OP_CTRL_WRITE, 8'h03);
        send_item(acia_sr_pkg::OP_CTRL_WRITE, 8'h03);
        send_item(acia_sr_pkg::OP_CTRL_WRITE, 8'h5C);
        send_item(acia_sr_pkg::OP_RX_READ, 8'h00);
    endtask

    // random traffic with the line enabled, then disabled, then enabled again
    task automatic test_random_traffic();
        write_enable(1'b1);
        send_item(acia_sr_pkg::OP_CTRL_WRITE, 8'hA0);
        run_seqs(1000);
        write_enable(1'b0);
        run_seqs(150);
        write_enable(1'b1);
        run_seqs(300);
    endtask

    // back to back transactions on both sides
    task automatic test_steady_stream();
        idle_on = 1'b0;
        run_seqs(300);
        wait_replies();
        idle_on = 1'b1;
    endtask

    // receiver holds off long enough for the input to stall
    task automatic test_receiver_stall();
        idle_on = 1'b0;
        rx_stall_left = 200;
        run_seqs(60);
        wait_replies();
        idle_on = 1'b1;
    endtask

    // sender waits for the adapter to drain between bursts
    task automatic test_sender_pause();
        repeat (5)
        begin
            run_seqs(25);
            wait_replies();
        end
    endtask

    // receiver side ready, with random hold-offs
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_stall_left > 0)
            begin
                m_tready <= 1'b0;
                rx_stall_left--;
            end
            else
                m_tready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    // compare each reply against the oldest prediction
    always @(posedge clk)
    begin
        acia_sr_pkg::result_t got;
        acia_sr_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[17:0];
            if (acia_replies_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("error: reply %h with nothing outstanding", m_tdata);
            end
            else
            begin
                want = acia_replies_q.pop_front();
                replies_checked++;
                if (got.tx_valid)
                    line_bytes++;
                if (got.irq_line)
                    irq_replies++;
                if (got.read_data !== want.read_data || got.irq_line !== want.irq_line ||
                    got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                    m_tdata[23:18] !== 6'b0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("error: reply %0d exp rd=%h irq=%b txv=%b txb=%h",
                                 replies_checked, want.read_data, want.irq_line,
                                 want.tx_valid, want.tx_byte);
                        $display("       got rd=%h irq=%b txv=%b txb=%h pad=%h",
                                 got.read_data, got.irq_line, got.tx_valid,
                                 got.tx_byte, m_tdata[23:18]);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // test sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_traffic();
        test_steady_stream();
        test_receiver_stall();
        test_sender_pause();
        wait_replies();
        repeat (4) @(posedge clk);
        $display("run: %0d transactions, %0d replies checked, %0d enable writes",
                 items_sent, replies_checked, enable_writes);
        $display("run: %0d bytes to the line, %0d replies with irq high, %0d mismatches",
                 line_bytes, irq_replies, mismatches);
        if (mismatches == 0 && acia_replies_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/acia_sr_pkg.sv
src/acia_serial_registers_top.sv
test/tb_top.sv
